// File: hw/rtl/rcts_pkg.sv
`default_nettype none
package rcts_pkg;

  localparam int MAX_PAGES = 16;

  localparam int CH_W    = 16;
  localparam int PAGE_W  = 4;
  localparam int MODE_W  = 2;
  localparam int REG_W   = 3;
  localparam int DATA_W  = 16;
  localparam int DIV_W   = 16;
  localparam int DIV_CNT_W = $clog2(DIV_W + 1);

  localparam logic [MODE_W-1:0] MODE_PERCENT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_TOGGLE  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PUSH    = 2'd2;
  localparam logic [MODE_W-1:0] MODE_DEMO    = 2'd3;

  localparam logic [REG_W-1:0] REG_SWITCH_MODE = 3'd0;
  localparam logic [REG_W-1:0] REG_PAGE_COUNT  = 3'd1;
  localparam logic [REG_W-1:0] REG_CHANNEL_MIN = 3'd2;
  localparam logic [REG_W-1:0] REG_CHANNEL_MAX = 3'd3;
  localparam logic [REG_W-1:0] REG_DEMO_PERIOD = 3'd4;

  localparam logic [MODE_W-1:0] RST_SWITCH_MODE = MODE_DEMO;
  localparam logic [PAGE_W-1:0] RST_PAGE_COUNT  = 4'd1;
  localparam logic [CH_W-1:0]   RST_CHANNEL_MIN = 16'd1000;
  localparam logic [CH_W-1:0]   RST_CHANNEL_MAX = 16'd2000;
  localparam logic [CH_W-1:0]   RST_DEMO_PERIOD = 16'd5000;

  typedef struct packed {
    logic [MODE_W-1:0] switch_mode;
    logic [PAGE_W-1:0] page_count;
    logic [CH_W-1:0]   channel_min;
    logic [CH_W-1:0]   channel_max;
    logic [CH_W-1:0]   demo_period_ms;
  } cfg_t;

endpackage
`default_nettype wire

// File: hw/rtl/rcts_if.sv
`default_nettype none
interface rcts_in_if;
  logic                        valid;
  logic                        ready;
  logic [rcts_pkg::CH_W-1:0]   channel_value;
  logic [rcts_pkg::CH_W-1:0]   time_ms;
  logic                        load_ready;

  modport source (output valid, channel_value, time_ms, load_ready, input ready);
  modport sink   (input valid, channel_value, time_ms, load_ready, output ready);
endinterface

interface rcts_out_if;
  logic                        valid;
  logic                        ready;
  logic [rcts_pkg::PAGE_W-1:0] page_index;
  logic                        page_changed;

  modport source (output valid, page_index, page_changed, input ready);
  modport sink   (input valid, page_index, page_changed, output ready);
endinterface

interface rcts_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [rcts_pkg::REG_W-1:0]  index;
  logic [rcts_pkg::DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/rcts_cfg.sv
`default_nettype none
module rcts_cfg (
  input  wire logic      clk,
  input  wire logic      rst,
  rcts_cfg_if.sink       cfg,
  output rcts_pkg::cfg_t regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.switch_mode    <= rcts_pkg::RST_SWITCH_MODE;
      regs.page_count     <= rcts_pkg::RST_PAGE_COUNT;
      regs.channel_min    <= rcts_pkg::RST_CHANNEL_MIN;
      regs.channel_max    <= rcts_pkg::RST_CHANNEL_MAX;
      regs.demo_period_ms <= rcts_pkg::RST_DEMO_PERIOD;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        rcts_pkg::REG_SWITCH_MODE: regs.switch_mode <= cfg.data[rcts_pkg::MODE_W-1:0];
        rcts_pkg::REG_PAGE_COUNT:  regs.page_count  <= cfg.data[rcts_pkg::PAGE_W-1:0];
        rcts_pkg::REG_CHANNEL_MIN: regs.channel_min <= cfg.data[rcts_pkg::CH_W-1:0];
        rcts_pkg::REG_CHANNEL_MAX: regs.channel_max <= cfg.data[rcts_pkg::CH_W-1:0];
        rcts_pkg::REG_DEMO_PERIOD: regs.demo_period_ms <= cfg.data[rcts_pkg::CH_W-1:0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/rcts_div.sv
`default_nettype none
module rcts_div (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [rcts_pkg::DIV_W-1:0] dividend,
  input  wire logic [rcts_pkg::DIV_W-1:0] divisor,
  output logic                            done,
  output logic [rcts_pkg::DIV_W-1:0]      quotient
);

  localparam int W  = rcts_pkg::DIV_W;
  localparam int CW = rcts_pkg::DIV_CNT_W;

  logic          busy;
  logic [CW-1:0] count;
  logic [W-1:0]  rem;
  logic [W-1:0]  dvs;
  logic [W:0]    trial;
  logic          fits;

  assign trial = {rem, quotient[W-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CW'(W);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      quotient <= dividend;
      dvs      <= divisor;
    end else if (busy) begin
      if (fits) begin
        rem <= W'(trial - {1'b0, dvs});
      end else begin
        rem <= trial[W-1:0];
      end
      quotient <= {quotient[W-2:0], fits};
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/rc_channel_tab_selector_unit.sv
// Channel  Dir  Handshake      Word
// cfg      in   valid/ready    index, data (always ready)
// sample   in   valid/ready    channel_value, time_ms, load_ready
// result   out  valid/ready    page_index, page_changed
//
// Toggle, push and demo modes: an accepted word goes through S_EVAL and S_FIN to the result.
// Percent mode: up to two passes of the shared 16-step restoring divider
// (span / page count, then offset / band) between S_EVAL and S_FIN.
// One word in flight; sample.ready drops from accept until the result is
// registered. A stalled result holds while the next word is taken.
// Synchronous reset restores the config registers, control state and page 0.
`default_nettype none
module rc_channel_tab_selector_unit (
  input  wire logic  clk,
  input  wire logic  rst,
  rcts_cfg_if.sink   cfg,
  rcts_in_if.sink    sample,
  rcts_out_if.source result
);

  localparam int CH_W   = rcts_pkg::CH_W;
  localparam int PAGE_W = rcts_pkg::PAGE_W;
  localparam int DIV_W  = rcts_pkg::DIV_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EVAL = 3'd1;
  localparam logic [2:0] S_DIVA = 3'd2;
  localparam logic [2:0] S_DIVB = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  rcts_pkg::cfg_t regs;

  logic [2:0]        state;
  logic [CH_W-1:0]   raw;
  logic [CH_W-1:0]   now;
  logic              ld_ok;
  logic [PAGE_W-1:0] cur_page;
  logic              prev_level;
  logic [CH_W-1:0]   demo_timer;
  logic [PAGE_W-1:0] target;
  logic              res_valid;
  logic [PAGE_W-1:0] res_page;
  logic              res_changed;

  logic [PAGE_W-1:0]  n;
  logic [PAGE_W:0]    step_page;
  logic [PAGE_W-1:0]  nxt;
  logic signed [CH_W:0]   span;
  logic signed [CH_W:0]   off;
  logic signed [CH_W+1:0] off2;
  logic               lvl;
  logic [CH_W-1:0]    diff;
  logic               band_ok;
  logic               out_free;

  logic             div_start;
  logic [DIV_W-1:0] div_dividend;
  logic [DIV_W-1:0] div_divisor;
  logic             div_done;
  logic [DIV_W-1:0] div_q;

  rcts_cfg u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  rcts_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    if (regs.page_count == '0) begin
      n = PAGE_W'(1);
    end else if (int'(regs.page_count) > rcts_pkg::MAX_PAGES - 1) begin
      n = PAGE_W'(rcts_pkg::MAX_PAGES - 1);
    end else begin
      n = regs.page_count;
    end
  end

  assign step_page = {1'b0, cur_page} + 1'b1;
  assign nxt       = (step_page > {1'b0, n}) ? PAGE_W'(1) : step_page[PAGE_W-1:0];

  assign span = $signed({1'b0, regs.channel_max}) - $signed({1'b0, regs.channel_min});
  assign off  = $signed({1'b0, raw}) - $signed({1'b0, regs.channel_min});
  assign off2 = {off, 1'b0};
  assign lvl  = !off[CH_W] && (off2 >= $signed({span[CH_W], span}));
  assign diff = now - demo_timer;

  assign band_ok  = !span[CH_W] && (span[CH_W-1:0] >= CH_W'(n));
  assign out_free = !res_valid || result.ready;

  always_comb begin
    div_start    = 1'b0;
    div_dividend = span[DIV_W-1:0];
    div_divisor  = DIV_W'(n);
    if (state == S_EVAL && regs.switch_mode == rcts_pkg::MODE_PERCENT && band_ok) begin
      div_start = 1'b1;
    end else if (state == S_DIVA) begin
      div_dividend = off[DIV_W-1:0];
      div_divisor  = div_q;
      div_start    = div_done && !off[CH_W];
    end
  end

  assign sample.ready        = (state == S_IDLE);
  assign result.valid        = res_valid;
  assign result.page_index   = res_page;
  assign result.page_changed = res_changed;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cur_page   <= '0;
      prev_level <= 1'b0;
      demo_timer <= '0;
      res_valid  <= 1'b0;
    end else begin
      if (res_valid && result.ready) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (sample.valid) begin
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          state <= S_FIN;
          case (regs.switch_mode)
            rcts_pkg::MODE_PERCENT: begin
              if (band_ok) begin
                state <= S_DIVA;
              end
            end
            rcts_pkg::MODE_TOGGLE: begin
              prev_level <= lvl;
            end
            rcts_pkg::MODE_PUSH: begin
              prev_level <= lvl;
            end
            default: begin
              if (diff > regs.demo_period_ms) begin
                demo_timer <= demo_timer + regs.demo_period_ms;
              end
            end
          endcase
        end
        S_DIVA: begin
          if (div_done) begin
            state <= off[CH_W] ? S_FIN : S_DIVB;
          end
        end
        S_DIVB: begin
          if (div_done) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            state       <= S_IDLE;
            res_valid   <= 1'b1;
            res_changed <= (target != cur_page) && ld_ok;
            if ((target != cur_page) && ld_ok) begin
              cur_page <= target;
              res_page <= target;
            end else begin
              res_page <= cur_page;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && sample.valid) begin
      raw   <= sample.channel_value;
      now   <= sample.time_ms;
      ld_ok <= sample.load_ready;
    end
    if (state == S_EVAL) begin
      target <= cur_page;
      case (regs.switch_mode)
        rcts_pkg::MODE_PERCENT: begin
          target <= n;
        end
        rcts_pkg::MODE_TOGGLE: begin
          if (lvl != prev_level) begin
            target <= nxt;
          end
        end
        rcts_pkg::MODE_PUSH: begin
          if (lvl && !prev_level) begin
            target <= nxt;
          end
        end
        default: begin
          if (diff > regs.demo_period_ms) begin
            target <= nxt;
          end
        end
      endcase
    end
    if (state == S_DIVA && div_done && off[CH_W]) begin
      target <= PAGE_W'(1);
    end
    if (state == S_DIVB && div_done) begin
      if (div_q >= DIV_W'(n)) begin
        target <= n;
      end else begin
        target <= div_q[PAGE_W-1:0] + 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/rcts_check.sv
`default_nettype none
module rcts_check (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        sample_valid,
  input wire logic                        sample_ready,
  input wire logic                        result_valid,
  input wire logic                        result_ready,
  input wire logic [rcts_pkg::PAGE_W-1:0] page_index,
  input wire logic                        page_changed
);

  a_reset_clears_result: assert property (@(posedge clk)
    $past(rst) |-> !result_valid)
    else $error("result valid right after reset");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    sample_valid && sample_ready |=> !sample_ready)
    else $error("sample taken while a word is in flight");

  a_change_not_startup: assert property (@(posedge clk) disable iff (rst)
    result_valid && page_changed |-> page_index != '0)
    else $error("page change reported to the startup page");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=>
      result_valid && $stable(page_index) && $stable(page_changed))
    else $error("stalled result word changed");

endmodule

bind rc_channel_tab_selector_unit rcts_check u_check (
  .clk          (clk),
  .rst          (rst),
  .sample_valid (sample.valid),
  .sample_ready (sample.ready),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .page_index   (result.page_index),
  .page_changed (result.page_changed)
);
`default_nettype wire

// File: dv/rc_channel_tab_selector_unit_tb.sv
`timescale 1ns / 1ps
module rc_channel_tab_selector_unit_tb;

  localparam int CH_W   = rcts_pkg::CH_W;
  localparam int PAGE_W = rcts_pkg::PAGE_W;
  localparam int MODE_W = rcts_pkg::MODE_W;
  localparam int REG_W  = rcts_pkg::REG_W;
  localparam int DATA_W = rcts_pkg::DATA_W;

  localparam int QUIET_LIMIT = 2000;
  localparam int PHASES = 28;
  localparam int PHASE_WORDS = 50;

  typedef struct packed {
    logic [PAGE_W-1:0] page;
    logic              changed;
  } page_word_t;

  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

  typedef struct {
    row_kind_t          kind;
    logic [REG_W-1:0]   idx;
    logic [DATA_W-1:0]  data;
    logic [CH_W-1:0]    ch;
    logic [CH_W-1:0]    tm;
    logic               lr;
    bit                 fixed;
    logic [PAGE_W-1:0]  fpage;
    logic               fchg;
  } stim_row_t;

  logic clk;
  logic rst;

  rcts_cfg_if cfg_if();
  rcts_in_if  sample_if();
  rcts_out_if result_if();

  rc_channel_tab_selector_unit dut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_if),
    .sample (sample_if),
    .result (result_if)
  );

  logic [MODE_W-1:0] sel_mode;
  logic [PAGE_W-1:0] sel_count;
  logic [CH_W-1:0]   span_lo;
  logic [CH_W-1:0]   span_hi;
  logic [CH_W-1:0]   step_period;
  logic [PAGE_W-1:0] track_page;
  logic              track_level;
  logic [CH_W-1:0]   track_timer;

  page_word_t pending_pages[$];
  int         mismatch_count;
  int         quiet_cycles;
  int         burst_left;
  bit         hold_req;

  stim_row_t dir_rows [0:40] = '{
    '{ROW_SAMPLE, rcts_pkg::REG_SWITCH_MODE, 16'd0, 16'd0,    16'd0,     1'b1, 1'b1, 4'd0, 1'b0},
    '{ROW_SAMPLE, rcts_pkg::REG_SWITCH_MODE, 16'd0, 16'hFFFF, 16'd5001,  1'b1, 1'b1, 4'd1, 1'b1},
    '{ROW_SAMPLE, rcts_pkg::REG_SWITCH_MODE, 16'd0, 16'd0,    16'hFFFF,  1'b1, 1'b0, 4'd0, 1'b0},
    '{ROW_WRITE,  rcts_pkg::REG_SWITCH_MODE, 16'(rcts_pkg::MODE_PERCENT),
      16'd0, 16'd0, 1'b0, 1'b0, 4'd0, 1'b0},
    '{ROW_WRITE,  rcts_pkg::REG_PAGE_COUNT,  16'd15,   16'd0, 16'd0, 1'b0, 1'b0, 4'd0, 1'b0},
    '{ROW_WRITE,  rcts_pkg::REG_CHANNEL_MIN, 16'd0,    16'd0, 16'd0, 1'b0, 1'b0, 4'd0, 1'b0},
    '{ROW_WRITE,  rcts_pkg::REG_CHANNEL_MAX, 16'hFFFF, 16'd0, 16'd0, 1'b0, 1'b0, 4'd0, 1'b0},
    '{ROW_SAMPLE, rcts_pkg::REG_SWITCH_MODE, 16'd0, 16'd0,    16'd0,     1'b1, 1'b0, 4'd0, 1'b0},
    '{ROW_SAMPLE, rcts_pkg::REG_SWITCH_MODE, 16'd0, 16'hFFFF, 16'd0,     1'b1, 1'b1, 4'd15, 1'b1},
    '{ROW_SAMPLE, rcts_pkg::REG_SWITCH_MODE, 16'd0, 16'd0,    16'd0,     1'b0, 1'b1, 4'd15, 1'b0},
    '{ROW_SAMPLE, rcts_pkg::REG_SWITCH_MODE, 16'd0, 16'd0,    16'd0,     1'b1, 1'b1, 4'd1, 1'b1},
    '{ROW_WRITE,  rcts_pkg::REG_CHANNEL_MIN, 16'd2000, 16'd0, 16'd0, 1'b0, 1'b0, 4'd0, 1'b0},
    '{ROW_WRITE,  rcts_pkg::REG_CHANNEL_MAX, 16'd1000, 16'd0, 16'd0, 1'b0, 1'b0, 4'd0, 1'b0},
    '{ROW_SAMPLE, rcts_pkg::REG_SWITCH_MODE, 16'd0, 16'd500,  16'd0,     1'b1, 1'b1, 4'd15, 1'b1},
    '{ROW_WRITE,  rcts_pkg::REG_PAGE_COUNT,  16'd0,    16'd0, 16'd0, 1'b0, 1'b0, 4'd0, 1'b0},
    '{ROW_SAMPLE, rcts_pkg::REG_SWITCH_MODE, 16'd0, 16'd500,  16'd0,     1'b1, 1'b1, 4'd1, 1'b1},
    '{ROW_WRITE,  rcts_pkg::REG_CHANNEL_MIN, 16'd100,  16'd0, 16'd0, 1'b0, 1'b0, 4'd0, 1'b0},
    '{ROW_WRITE,  rcts_pkg::REG_CHANNEL_MAX, 16'd105,  16'd0, 16'd0, 1'b0, 1'b0, 4'd0, 1'b0},
    '{ROW_WRITE,  rcts_pkg::REG_PAGE_COUNT,  16'd7,    16'd0, 16'd0, 1'b0, 1'b0, 4'd0, 1'b0},
    '{ROW_SAMPLE, rcts_pkg::REG_SWITCH_MODE, 16'd0, 16'd100,  16'd0,     1'b1, 1'b0, 4'd0, 1'b0},
    '{ROW_WRITE,  rcts_pkg::REG_SWITCH_MODE, 16'(rcts_pkg::MODE_TOGGLE),
      16'd0, 16'd0, 1'b0, 1'b0, 4'd0, 1'b0},
    '{ROW_WRITE,  rcts_pkg::REG_CHANNEL_MIN, 16'd1000, 16'd0, 16'd0, 1'b0, 1'b0, 4'd0, 1'b0},
    '{ROW_WRITE,  rcts_pkg::REG_CHANNEL_MAX, 16'd2000, 16'd0, 16'd0, 1'b0, 1'b0, 4'd0, 1'b0},
    '{ROW_WRITE,  rcts_pkg::REG_PAGE_COUNT,  16'd3,    16'd0, 16'd0, 1'b0, 1'b0, 4'd0, 1'b0},
    '{ROW_SAMPLE, rcts_pkg::REG_SWITCH_MODE, 16'd0, 16'd2000, 16'd0,     1'b1, 1'b0, 4'd0, 1'b0},
    '{ROW_SAMPLE, rcts_pkg::REG_SWITCH_MODE, 16'd0, 16'd1000, 16'd0,     1'b1, 1'b0, 4'd0, 1'b0},
    '{ROW_SAMPLE, rcts_pkg::REG_SWITCH_MODE, 16'd0, 16'd1500, 16'd0,     1'b0, 1'b0, 4'd0, 1'b0},
    '{ROW_SAMPLE, rcts_pkg::REG_SWITCH_MODE, 16'd0, 16'hFFFF, 16'd0,     1'b1, 1'b0, 4'd0, 1'b0},
    '{ROW_SAMPLE, rcts_pkg::REG_SWITCH_MODE, 16'd0, 16'd0,    16'd0,     1'b1, 1'b0, 4'd0, 1'b0},
    '{ROW_SAMPLE, rcts_pkg::REG_SWITCH_MODE, 16'd0, 16'd1499, 16'd0,     1'b1, 1'b0, 4'd0, 1'b0},
    '{ROW_WRITE,  rcts_pkg::REG_SWITCH_MODE, 16'(rcts_pkg::MODE_PUSH),
      16'd0, 16'd0, 1'b0, 1'b0, 4'd0, 1'b0},
    '{ROW_SAMPLE, rcts_pkg::REG_SWITCH_MODE, 16'd0, 16'd1500, 16'd0,     1'b1, 1'b0, 4'd0, 1'b0},
    '{ROW_SAMPLE, rcts_pkg::REG_SWITCH_MODE, 16'd0, 16'd0,    16'd0,     1'b1, 1'b0, 4'd0, 1'b0},
    '{ROW_SAMPLE, rcts_pkg::REG_SWITCH_MODE, 16'd0, 16'hFFFF, 16'd0,     1'b1, 1'b0, 4'd0, 1'b0},
    '{ROW_WRITE,  rcts_pkg::REG_SWITCH_MODE, 16'(rcts_pkg::MODE_DEMO),
      16'd0, 16'd0, 1'b0, 1'b0, 4'd0, 1'b0},
    '{ROW_WRITE,  rcts_pkg::REG_DEMO_PERIOD, 16'd0,    16'd0, 16'd0, 1'b0, 1'b0, 4'd0, 1'b0},
    '{ROW_SAMPLE, rcts_pkg::REG_SWITCH_MODE, 16'd0, 16'd0,    16'd10000, 1'b1, 1'b0, 4'd0, 1'b0},
    '{ROW_SAMPLE, rcts_pkg::REG_SWITCH_MODE, 16'd0, 16'd0,    16'd10001, 1'b1, 1'b0, 4'd0, 1'b0},
    '{ROW_SAMPLE, rcts_pkg::REG_SWITCH_MODE, 16'd0, 16'd0,    16'd10001, 1'b1, 1'b0, 4'd0, 1'b0},
    '{ROW_WRITE,  rcts_pkg::REG_DEMO_PERIOD, 16'hFFFF, 16'd0, 16'd0, 1'b0, 1'b0, 4'd0, 1'b0},
    '{ROW_SAMPLE, rcts_pkg::REG_SWITCH_MODE, 16'd0, 16'hAAAA, 16'h5555,  1'b1, 1'b0, 4'd0, 1'b0}
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [PAGE_W-1:0] next_page_of(input int n);
    int p;
    p = int'(track_page) + 1;
    if (p > n)
      p = 1;
    return PAGE_W'(p);
  endfunction

  function automatic void predict_page(input logic [CH_W-1:0] ch, input logic [CH_W-1:0] tm,
                                       input logic lr, output page_word_t w);
    int n, span, off, div, v;
    logic [PAGE_W-1:0] target;
    logic [CH_W-1:0]   elapsed;
    logic              lvl;
    n = (sel_count == 0) ? 1 : int'(sel_count);
    if (n > rcts_pkg::MAX_PAGES - 1)
      n = rcts_pkg::MAX_PAGES - 1;
    span = int'(span_hi) - int'(span_lo);
    off = int'(ch) - int'(span_lo);
    lvl = (off >= 0) && (2 * off >= span);
    target = track_page;
    case (sel_mode)
      rcts_pkg::MODE_PERCENT: begin
        div = span / n;
        if (div <= 0)
          v = n - 1;
        else if (off < 0)
          v = 0;
        else
          v = off / div;
        if (v >= n)
          v = n - 1;
        target = PAGE_W'(v + 1);
      end
      rcts_pkg::MODE_TOGGLE: begin
        if (lvl != track_level) begin
          target = next_page_of(n);
          track_level = lvl;
        end
      end
      rcts_pkg::MODE_PUSH: begin
        if (track_level && !lvl) begin
          track_level = 1'b0;
        end else if (lvl && !track_level) begin
          target = next_page_of(n);
          track_level = 1'b1;
        end
      end
      default: begin
        elapsed = tm - track_timer;
        if (elapsed > step_period) begin
          track_timer = track_timer + step_period;
          target = next_page_of(n);
        end
      end
    endcase
    w.changed = 1'b0;
    if (target != track_page && lr) begin
      track_page = target;
      w.changed = 1'b1;
    end
    w.page = track_page;
  endfunction

  task automatic write_reg(input logic [REG_W-1:0] idx, input logic [DATA_W-1:0] val);
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    cfg_if.valid <= 1'b1;
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      rcts_pkg::REG_SWITCH_MODE: sel_mode    = val[MODE_W-1:0];
      rcts_pkg::REG_PAGE_COUNT:  sel_count   = val[PAGE_W-1:0];
      rcts_pkg::REG_CHANNEL_MIN: span_lo     = val[CH_W-1:0];
      rcts_pkg::REG_CHANNEL_MAX: span_hi     = val[CH_W-1:0];
      rcts_pkg::REG_DEMO_PERIOD: step_period = val[CH_W-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic send_sample(input logic [CH_W-1:0] ch, input logic [CH_W-1:0] tm,
                             input logic lr, input bit fixed, input page_word_t fixed_word);
    page_word_t want;
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 40);
      if (gap > 0) begin
        sample_if.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    sample_if.channel_value <= ch;
    sample_if.time_ms       <= tm;
    sample_if.load_ready    <= lr;
    sample_if.valid         <= 1'b1;
    do @(posedge clk); while (!sample_if.ready);
    predict_page(ch, tm, lr, want);
    pending_pages.push_back(fixed ? fixed_word : want);
    @(negedge clk);
  endtask

  // drain every expected word so the block sits idle
  task automatic settle();
    sample_if.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending_pages.size() != 0);
    @(negedge clk);
  endtask

  always @(posedge clk) begin : check_results
    page_word_t want;
    if (!rst && result_if.valid && result_if.ready) begin
      if (pending_pages.size() == 0) begin
        if (mismatch_count < 10)
          $display("unexpected word: page %0d changed %0d",
                   result_if.page_index, result_if.page_changed);
        mismatch_count++;
      end else begin
        want = pending_pages.pop_front();
        if (result_if.page_index !== want.page || result_if.page_changed !== want.changed) begin
          if (mismatch_count < 10)
            $display("mismatch: expected page %0d changed %0d, got page %0d changed %0d",
                     want.page, want.changed, result_if.page_index, result_if.page_changed);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (sample_if.valid && sample_if.ready) || (result_if.valid && result_if.ready)
        || (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("rc_channel_tab_selector_unit regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : result_stall
    int hold_left;
    int pat_left;
    logic [7:0] pat;
    hold_left = 0;
    pat_left = 0;
    pat = 8'hFF;
    result_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_if.ready <= 1'b0;
      end else begin
        if (pat_left == 0) begin
          pat = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom);
          if (pat == 8'h00)
            pat = 8'h01;
          pat_left = $urandom_range(16, 200);
        end
        pat_left--;
        pat = {pat[6:0], pat[7]};
        result_if.ready <= pat[0];
      end
    end
  end

  initial begin
    stim_row_t row;
    bit cfg_open;
    int ph, k, lo, hi;
    int c_mode, c_count, c_min, c_max, c_period;
    logic [CH_W-1:0] ch;
    logic [CH_W-1:0] clock_ms;

    rst = 1'b1;
    sample_if.valid = 1'b0;
    sample_if.channel_value = '0;
    sample_if.time_ms = '0;
    sample_if.load_ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    hold_req = 1'b0;
    mismatch_count = 0;
    quiet_cycles = 0;
    burst_left = 0;
    sel_mode = rcts_pkg::RST_SWITCH_MODE;
    sel_count = rcts_pkg::RST_PAGE_COUNT;
    span_lo = rcts_pkg::RST_CHANNEL_MIN;
    span_hi = rcts_pkg::RST_CHANNEL_MAX;
    step_period = rcts_pkg::RST_DEMO_PERIOD;
    track_page = '0;
    track_level = 1'b0;
    track_timer = '0;
    clock_ms = '0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    cfg_open = 1'b0;
    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.kind == ROW_WRITE) begin
        if (!cfg_open)
          settle();
        write_reg(row.idx, row.data);
        cfg_open = 1'b1;
      end else begin
        if (cfg_open) begin
          cfg_if.valid <= 1'b0;
          cfg_open = 1'b0;
        end
        send_sample(row.ch, row.tm, row.lr, row.fixed, '{row.fpage, row.fchg});
      end
    end

    for (ph = 0; ph < PHASES; ph++) begin
      settle();
      c_mode = ph % 4;
      case ($urandom_range(0, 5))
        0: c_count = 0;
        1: c_count = 1;
        2: c_count = 15;
        default: c_count = $urandom_range(2, 14);
      endcase
      case ($urandom_range(0, 5))
        0: begin
          c_min = 0;
          c_max = 65535;
        end
        1: begin
          c_max = $urandom_range(0, 30000);
          c_min = c_max + $urandom_range(1, 35535);
        end
        2: begin
          c_min = $urandom_range(0, 65000);
          c_max = c_min + $urandom_range(0, 20);
        end
        default: begin
          c_min = $urandom_range(0, 40000);
          c_max = c_min + $urandom_range(100, 25535);
        end
      endcase
      case ($urandom_range(0, 5))
        0: c_period = 0;
        1: c_period = 1;
        2: c_period = 65535;
        default: c_period = $urandom_range(2, 3000);
      endcase
      if (ph == 0) begin
        c_count = 15;
        c_min = 0;
        c_max = 65535;
      end else if (ph == 1) begin
        c_count = 0;
        c_min = 65535;
        c_max = 0;
        c_period = 65535;
      end else if (ph == 3) begin
        c_count = 15;
        c_period = 0;
      end
      write_reg(rcts_pkg::REG_SWITCH_MODE, DATA_W'(c_mode));
      write_reg(rcts_pkg::REG_PAGE_COUNT, DATA_W'(c_count));
      write_reg(rcts_pkg::REG_CHANNEL_MIN, DATA_W'(c_min));
      write_reg(rcts_pkg::REG_CHANNEL_MAX, DATA_W'(c_max));
      write_reg(rcts_pkg::REG_DEMO_PERIOD, DATA_W'(c_period));
      cfg_if.valid <= 1'b0;
      lo = (c_min < c_max) ? c_min : c_max;
      hi = (c_min < c_max) ? c_max : c_min;
      for (k = 0; k < PHASE_WORDS; k++) begin
        if (ph == 9 && k == 5)
          hold_req = 1'b1;
        case ($urandom_range(0, 9))
          0, 1: ch = CH_W'($urandom);
          2: ch = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
          default: ch = CH_W'(lo + $urandom_range(0, hi - lo));
        endcase
        if ($urandom_range(0, 9) == 0)
          clock_ms = CH_W'($urandom);
        else
          clock_ms = clock_ms + CH_W'($urandom_range(0, 4000));
        send_sample(ch, clock_ms, $urandom_range(0, 4) != 0, 1'b0, '0);
      end
    end

    sample_if.valid <= 1'b0;
    while (pending_pages.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatch_count == 0 && pending_pages.size() == 0)
      $display("rc_channel_tab_selector_unit regression: pass");
    else
      $display("rc_channel_tab_selector_unit regression: fail");
    $finish;
  end

endmodule
